// ===== src/imtr_pkg.sv =====
// Package for the int8 matmul tile requantization core.
// Holds payload structs, register indexes and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imtr_pkg;
    localparam int OPERANDS = 4;

    typedef struct packed {
        logic signed [7:0] a_row0;
        logic signed [7:0] a_row1;
        logic signed [7:0] a_row2;
        logic signed [7:0] a_row3;
        logic signed [7:0] b_col0;
        logic signed [7:0] b_col1;
        logic signed [7:0] b_col2;
        logic signed [7:0] b_col3;
        logic              final_step;
        logic        [2:0] rows_used;
        logic        [2:0] cols_used;
    } t_in_item;

    typedef struct packed {
        logic        [1:0] out_row;
        logic        [1:0] out_col;
        logic signed [7:0] out_value;
        logic              out_last;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_ZERO_A = 3'd0,
        REG_ZERO_B = 3'd1,
        REG_ZERO_O = 3'd2,
        REG_MULT   = 3'd3,
        REG_SHIFT  = 3'd4
    } t_reg_idx;

    // per-cell control broadcast to every cell of the array
    typedef struct packed {
        logic step;   // add the product this cycle
        logic load;   // capture the step result and clear (final step)
        logic shift;  // hand the held value to the next cell
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== src/imtr_cell.sv =====
// One accumulator cell of the tile chain.
// Accumulates (a-z1)*(b-z2); on drain shifts its word toward the chain head. Uses imtr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imtr_cell
    import imtr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic signed [8:0] i_da,
    input  wire logic signed [8:0] i_db,
    input  wire logic       [31:0] i_shift_in,
    output logic            [31:0] o_hold
);
    logic [31:0] r_acc, n_acc, r_hold, n_hold;
    logic signed [17:0] w_prod;
    logic [31:0] w_sum;

    assign w_prod = i_da * i_db;
    assign w_sum  = r_acc + {{14{w_prod[17]}}, w_prod};

    always_comb begin
        n_acc  = r_acc;
        n_hold = r_hold;
        if (i_ctl.step) n_acc = w_sum;
        if (i_ctl.load) begin
            n_hold = w_sum;
            n_acc  = '0;
        end else if (i_ctl.shift) begin
            n_hold = i_shift_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_acc <= '0;
        else r_acc <= n_acc;
        r_hold <= n_hold;
    end

    assign o_hold = r_hold;
endmodule
`default_nettype wire

// ===== src/imtr_requant.sv =====
// Two-stage requantizer: Q31 multiply, then rounding shift, zero add, saturation.
// Uses imtr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imtr_requant
    import imtr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_acc,
    input  wire logic signed [31:0] i_mult,
    input  wire logic signed [5:0]  i_shift,
    input  wire logic signed [7:0]  i_zero,
    output logic signed [7:0]       o_value
);
    logic signed [63:0] w_prod;
    logic signed [31:0] r_hi, w_sh;
    logic [4:0] w_s;
    logic w_rnd;
    logic signed [33:0] w_v;

    assign w_prod = i_acc * i_mult;
    always_ff @(posedge i_clk) r_hi <= w_prod[63:32];

    // amount is -shift-1 mod 32, i.e. the low bits of ~shift
    assign w_s   = ~i_shift[4:0];
    assign w_sh  = r_hi >>> w_s;
    assign w_rnd = (w_s != 5'd0) ? r_hi[w_s - 5'd1] : 1'b0;
    assign w_v   = {{2{w_sh[31]}}, w_sh} + {33'd0, w_rnd} + {{26{i_zero[7]}}, i_zero};

    always_comb begin
        if (w_v > 34'sd127) o_value = 8'sd127;
        else if (w_v < -34'sd128) o_value = -8'sd128;
        else o_value = w_v[7:0];
    end
endmodule
`default_nettype wire

// ===== src/int8_matmul_tile_requant_core.sv =====
// Top level of the int8 matmul tile requantization core.
// Depends on imtr_pkg, imtr_cell and imtr_requant.
//
// Input channel (i_in_valid/o_in_ready, payload i_in) takes one inner step per
// item. A non-final step only accumulates: the cell array adds the sixteen
// products in parallel. A final step adds its products, copies every
// accumulator into the cell's hold register and clears the accumulator.
// The hold registers then form a chain that shifts toward cell 0 once a
// cycle while the output is not stalled; cell 0 feeds a requantizer
// (registered multiply, then shift/round/saturate) and an output register.
// Results leave row-major, one per cycle while the receiver is ready, with a
// gap for each unused chain position; out_last marks the final one. Input is
// not accepted from the final step until the last result has been taken; a
// tile with zero used rows or columns yields no results and does not block.
// Accumulation runs at one item per cycle while no tile is draining. A receiver
// stall holds the output register and freezes the chain and requantizer.
// Synchronous active-low reset clears accumulators, registers to their
// reset values and all control state. Configuration writes are taken any cycle.
`timescale 1ns / 1ps
`default_nettype none
module int8_matmul_tile_requant_core
    import imtr_pkg::*;
#(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    localparam int NCELL = TILE_ROWS * TILE_COLS;
    localparam int RMAX = (TILE_ROWS < OPERANDS) ? TILE_ROWS : OPERANDS;
    localparam int CMAX = (TILE_COLS < OPERANDS) ? TILE_COLS : OPERANDS;
    localparam int CW = (NCELL > 1) ? $clog2(NCELL) : 1;

    logic signed [7:0]  r_za, r_zb, r_zo;
    logic signed [31:0] r_mult;
    logic signed [5:0]  r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_za <= '0; r_zb <= '0; r_zo <= '0;
            r_mult <= 32'sd1073741824; r_shift <= -6'sd1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ZERO_A: r_za <= i_cfg_data[7:0];
                REG_ZERO_B: r_zb <= i_cfg_data[7:0];
                REG_ZERO_O: r_zo <= i_cfg_data[7:0];
                REG_MULT:   r_mult <= i_cfg_data;
                REG_SHIFT:  r_shift <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // drain control: chain position r_pos, used rows/cols, next row/col, stage valids
    logic         r_drain, n_drain;
    logic [2:0]   r_nr, r_nc, n_nr, n_nc, w_nr, w_nc;
    logic [1:0]   r_row, r_col, n_row, n_col;
    logic [CW:0]  r_pos, n_pos;
    logic         r_v1, n_v1;
    t_out_item    r_m1, n_m1;
    logic         r_ov, n_ov;
    t_out_item    r_out, n_out;
    logic         w_adv, w_take, w_acc, w_pass;
    logic signed [7:0] w_val;
    t_cell_ctl    w_ctl;

    assign o_in_ready = !r_drain;
    assign w_acc  = i_in_valid && o_in_ready;
    assign w_adv  = !r_ov || i_out_ready;   // pipeline moves
    assign w_nr   = (i_in.rows_used > 3'(RMAX)) ? 3'(RMAX) : i_in.rows_used;
    assign w_nc   = (i_in.cols_used > 3'(CMAX)) ? 3'(CMAX) : i_in.cols_used;

    // element (row,col) is taken from cell 0 when its chain position arrives
    assign w_take = r_drain && w_adv && (r_row < r_nr[1:0] || r_nr == 3'd4)
                    && r_pos == (CW+1)'(r_row * TILE_COLS + r_col);
    assign w_pass = r_drain && w_adv && !w_take && (r_pos < (CW+1)'(NCELL));

    assign w_ctl.step  = w_acc;
    assign w_ctl.load  = w_acc && i_in.final_step;
    assign w_ctl.shift = w_take || w_pass;

    logic signed [8:0] w_da [TILE_ROWS];
    logic signed [8:0] w_db [TILE_COLS];
    logic [31:0] w_hold [NCELL+1];
    assign w_hold[NCELL] = '0;

    genvar gr, gc;
    generate
        for (gr = 0; gr < TILE_ROWS; gr++) begin : g_da
            if (gr < OPERANDS) begin : g_op
                assign w_da[gr] = 9'($signed(i_in[8*(2*OPERANDS-1-gr) + 7 +: 8]))
                                  - 9'(r_za);
            end else begin : g_zero
                assign w_da[gr] = '0;
            end
        end
        for (gc = 0; gc < TILE_COLS; gc++) begin : g_db
            if (gc < OPERANDS) begin : g_op
                assign w_db[gc] = 9'($signed(i_in[8*(OPERANDS-1-gc) + 7 +: 8]))
                                  - 9'(r_zb);
            end else begin : g_zero
                assign w_db[gc] = '0;
            end
        end
        for (gr = 0; gr < TILE_ROWS; gr++) begin : g_row
            for (gc = 0; gc < TILE_COLS; gc++) begin : g_col
                imtr_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_ctl      (w_ctl),
                    .i_da       (w_da[gr]),
                    .i_db       (w_db[gc]),
                    .i_shift_in (w_hold[gr*TILE_COLS + gc + 1]),
                    .o_hold     (w_hold[gr*TILE_COLS + gc])
                );
            end
        end
    endgenerate

    always_comb begin
        n_drain = r_drain; n_nr = r_nr; n_nc = r_nc;
        n_row = r_row; n_col = r_col; n_pos = r_pos;
        n_v1 = r_v1; n_m1 = r_m1;
        n_ov = r_ov; n_out = r_out;
        if (w_ctl.load) begin
            n_nr = w_nr; n_nc = w_nc; n_row = '0; n_col = '0; n_pos = '0;
            n_drain = (w_nr != 3'd0) && (w_nc != 3'd0);
        end else if (w_ctl.shift) begin
            n_pos = r_pos + 1'b1;
        end
        if (w_adv) begin
            n_v1 = w_take;
            n_m1.out_row = r_row;
            n_m1.out_col = r_col;
            n_m1.out_value = '0;
            n_m1.out_last = (3'(r_row) == r_nr - 3'd1) && (3'(r_col) == r_nc - 3'd1);
            n_ov = r_v1; n_out = r_m1; n_out.out_value = w_val;
            if (w_take) begin
                if (3'(r_col) == r_nc - 3'd1) begin
                    n_col = '0; n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
        // release input once the last result leaves the output register
        if (r_ov && i_out_ready && r_out.out_last) n_drain = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0; r_v1 <= 1'b0; r_ov <= 1'b0;
            r_nr <= '0; r_nc <= '0; r_row <= '0; r_col <= '0; r_pos <= '0;
        end else begin
            r_drain <= n_drain; r_v1 <= n_v1; r_ov <= n_ov;
            r_nr <= n_nr; r_nc <= n_nc; r_row <= n_row; r_col <= n_col;
            r_pos <= n_pos;
        end
        r_m1 <= n_m1; r_out <= n_out;
    end

    // requantizer stage 1 registers on w_adv via a held accumulator copy
    logic signed [31:0] r_acc0;
    logic signed [7:0]  w_rq;
    always_ff @(posedge i_clk) if (w_adv) r_acc0 <= w_hold[0];

    imtr_requant u_rq (
        .i_clk   (i_clk),
        .i_acc   (w_adv ? w_hold[0] : r_acc0),
        .i_mult  (r_mult),
        .i_shift (r_shift),
        .i_zero  (r_zo),
        .o_value (w_rq)
    );
    assign w_val = w_rq;

    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule
`default_nettype wire

// ===== src/imtr_checker.sv =====
// Port-level checker for the tile core, bound to the top level.
// Depends on imtr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imtr_checker
    import imtr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output item changed under stall");
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted while tile results pending");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.out_last |=> o_in_ready)
        else $error("input not released after last item");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
endmodule

bind int8_matmul_tile_requant_core imtr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out(o_out)
);
`default_nettype wire

// ===== dv/tb_int8_matmul_tile_requant_core.sv =====
// Testbench for int8_matmul_tile_requant_core: drives inner steps and tile ends,
// predicts the requantized int8 tile results and checks each result item.
// Depends on imtr_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_int8_matmul_tile_requant_core;
    import imtr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    int8_matmul_tile_requant_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [31:0]        acc_q [16];
    logic signed [7:0]  zero_a, zero_b, zero_o;
    logic signed [31:0] mult;
    logic signed [5:0]  shamt;
    t_out_item          tile_results [$];

    int errors;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_int8_matmul_tile_requant_core failed");
        $finish;
    end

    function automatic logic signed [7:0] requantize(logic [31:0] acc);
        logic signed [63:0] prod;
        logic signed [31:0] hi;
        logic [4:0]         s;
        logic signed [63:0] v;
        prod = $signed(acc) * 64'(mult);
        hi   = prod[63:32];
        s    = 5'(-shamt - 6'sd1);
        v    = 64'(hi >>> s);
        if (s != 0) v = v + 64'(hi[s - 1]);
        v = v + 64'(zero_o);
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return v[7:0];
    endfunction

    task automatic predict_step(t_in_item it);
        logic signed [8:0]  da [4];
        logic signed [8:0]  db [4];
        logic signed [31:0] p;
        int nr, nc;
        t_out_item res;
        da[0] = it.a_row0 - zero_a; da[1] = it.a_row1 - zero_a;
        da[2] = it.a_row2 - zero_a; da[3] = it.a_row3 - zero_a;
        db[0] = it.b_col0 - zero_b; db[1] = it.b_col1 - zero_b;
        db[2] = it.b_col2 - zero_b; db[3] = it.b_col3 - zero_b;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                p = 32'(da[r]) * 32'(db[c]);
                acc_q[r*4+c] = acc_q[r*4+c] + p;
            end
        if (!it.final_step) return;
        nr = (it.rows_used > 4) ? 4 : it.rows_used;
        nc = (it.cols_used > 4) ? 4 : it.cols_used;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
                res.out_row   = 2'(r);
                res.out_col   = 2'(c);
                res.out_value = requantize(acc_q[r*4+c]);
                res.out_last  = (r == nr-1 && c == nc-1);
                tile_results.push_back(res);
            end
        foreach (acc_q[i]) acc_q[i] = '0;
    endtask

    // valid stays high after acceptance until the next idle or pause drops it
    task automatic send_step(t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_step(it);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_ZERO_A: zero_a = data[7:0];
            REG_ZERO_B: zero_b = data[7:0];
            REG_ZERO_O: zero_o = data[7:0];
            REG_MULT:   mult   = data;
            REG_SHIFT:  shamt  = data[5:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait until every tile result is out, then let the pipeline settle
    task automatic drain_tiles();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (tile_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_step(bit fin, int wide);
        t_in_item it;
        it = t_in_item'(71'({$urandom, $urandom, $urandom}));
        it.final_step = fin;
        // mostly in-range sizes, some above the limit and some zero
        it.rows_used = (wide == 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        it.cols_used = (wide == 0) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_tile(int depth, int wide);
        for (int k = 0; k < depth; k++)
            send_step(rand_step(k == depth - 1, wide));
    endtask

    task automatic test_directed();
        t_in_item it;
        // extremes: largest magnitude products accumulate
        it = '0;
        it.a_row0 = -128; it.a_row1 = 127; it.a_row2 = -128; it.a_row3 = 0;
        it.b_col0 = -128; it.b_col1 = 127; it.b_col2 = 1;    it.b_col3 = -1;
        it.rows_used = 4; it.cols_used = 4;
        repeat (3) send_step(it);
        it.final_step = 1'b1;
        send_step(it);
        // counts above limit
        it.rows_used = 7; it.cols_used = 5;
        send_step(it);
        // zero counts still clear
        it.rows_used = 0; it.cols_used = 3;
        send_step(it);
        it.rows_used = 2; it.cols_used = 0;
        send_step(it);
        it.rows_used = 1; it.cols_used = 1;
        send_step(it);
        it.a_row0 = 127; it.b_col0 = 127;
        it.rows_used = 1; it.cols_used = 4;
        send_step(it);
        it = '1; it.final_step = 1'b1;
        send_step(it);
        drain_tiles();
    endtask

    task automatic test_config_extremes();
        logic [31:0] mults [4];
        logic [5:0]  shifts [5];
        mults  = '{32'h7fffffff, 32'h80000000, 32'h00000001, 32'h40000000};
        shifts = '{6'h3f, 6'h20, 6'h30, 6'h00, 6'h1f};
        for (int i = 0; i < 5; i++) begin
            write_reg(REG_ZERO_A, (i % 2) ? 32'h80 : 32'h7f);
            write_reg(REG_ZERO_B, (i % 2) ? 32'h7f : 32'h80);
            write_reg(REG_ZERO_O, (i % 3 == 0) ? 32'h80 : 32'h7f);
            write_reg(REG_MULT, mults[i % 4]);
            write_reg(REG_SHIFT, 32'(shifts[i]));
            repeat (4) send_tile($urandom_range(1, 4), 1);
            drain_tiles();
        end
    endtask

    task automatic test_random(int tiles);
        for (int t = 0; t < tiles; t++) begin
            if (t % 20 == 0) begin
                drain_tiles();
                write_reg(REG_ZERO_A, $urandom);
                write_reg(REG_ZERO_B, $urandom);
                write_reg(REG_ZERO_O, $urandom);
                write_reg(REG_MULT, $urandom);
                write_reg(REG_SHIFT, 32'($urandom_range(32, 63)));
            end
            send_tile($urandom_range(1, 6), ($urandom_range(9) == 0));
        end
        drain_tiles();
    endtask

    task automatic test_backpressure();
        // receiver holds off long while tiles keep coming
        hold_cycles = 200;
        repeat (3) send_tile(2, 0);
        i_in_valid <= 1'b0;
        while (hold_cycles != 0) @(posedge i_clk);
        drain_tiles();
        // sender pauses until everything arrived
        send_tile(3, 0);
        drain_tiles();
        send_tile(3, 0);
        drain_tiles();
    endtask

    // result side: stall pattern and checking
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready && i_rst_n) begin
                if (tile_results.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result item row %0d col %0d value %0d",
                                 o_out.out_row, o_out.out_col, o_out.out_value);
                end else begin
                    t_out_item exp_res;
                    exp_res = tile_results.pop_front();
                    if (o_out.out_row !== exp_res.out_row
                        || o_out.out_col !== exp_res.out_col
                        || o_out.out_value !== exp_res.out_value
                        || o_out.out_last !== exp_res.out_last) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: exp r%0d c%0d v%0d l%0d got r%0d c%0d v%0d l%0d",
                                     exp_res.out_row, exp_res.out_col, exp_res.out_value,
                                     exp_res.out_last, o_out.out_row, o_out.out_col,
                                     o_out.out_value, o_out.out_last);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_ZERO_A;
        i_cfg_data <= '0;
        foreach (acc_q[i]) acc_q[i] = '0;
        zero_a = 0; zero_b = 0; zero_o = 0;
        mult = 32'sd1073741824; shamt = -6'sd1;
        errors = 0; mismatches = 0; hold_cycles = 0;
        send_idle_pct = 35; recv_idle_pct = 47;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_extremes();
        test_random(40);
        send_idle_pct = 47; recv_idle_pct = 35;
        test_random(40);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(40);
        test_backpressure();

        drain_tiles();
        if (errors == 0 && tile_results.size() == 0)
            $display("tb_int8_matmul_tile_requant_core passed");
        else
            $display("tb_int8_matmul_tile_requant_core failed");
        $finish;
    end
endmodule
